// ===== rtl/eaiir_pkg.sv =====
package eaiir_pkg;

	localparam int FieldWidth = 48;
	localparam int CoefWidth  = 24;
	localparam int CfgWidth   = 32;
	localparam int CfgIdxW    = 3;
	localparam int JointW     = 4;

	typedef enum logic [CfgIdxW-1:0] {
		REG_INVERT_MASK = 3'd0,
		REG_ANGLE_SCALE = 3'd1,
		REG_B_OUTER     = 3'd2,
		REG_B_INNER     = 3'd3,
		REG_A_FIRST     = 3'd4,
		REG_A_SECOND    = 3'd5,
		REG_A_THIRD     = 3'd6,
		REG_STEP_RATE   = 3'd7
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ANGLE,
		ST_READ,
		ST_MAC,
		ST_VEL,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic                     mode;
		logic [JointW-1:0]        joint_index;
		logic signed [31:0]       enc_count;
		logic signed [31:0]       zero_count;
		logic signed [FieldWidth-1:0] preset_angle;
	} in_beat_t;

	typedef struct packed {
		logic [JointW-1:0]            joint_out;
		logic signed [FieldWidth-1:0] position;
		logic signed [FieldWidth-1:0] velocity;
	} out_beat_t;

	typedef struct packed {
		logic start;
	} mul_ctl_t;

endpackage

// ===== rtl/eaiir_if.sv =====
interface eaiir_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/eaiir_sermul.sv =====
// Digit-serial signed multiplier: 4 bits of the multiplicand per cycle.
module eaiir_sermul #(
	parameter int AW = 66,
	parameter int BW = 34
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  eaiir_pkg::mul_ctl_t      ctl,
	input  logic signed [AW-1:0]     a,
	input  logic signed [BW-1:0]     b,
	output logic                     done,
	output logic signed [AW+BW-1:0]  p
);
	import eaiir_pkg::*;

	localparam int Digits = (AW + 3) / 4;
	localparam int PadW   = Digits * 4;
	localparam int CntW   = $clog2(Digits + 1);

	logic [PadW-1:0]           a_q;
	logic signed [BW-1:0]      b_q;
	logic signed [AW+BW-1:0]   acc_q;
	logic [CntW-1:0]           cnt_q;
	logic                      run_q;
	logic                      last;
	logic signed [BW+4:0]      part;
	logic signed [4:0]         dig;

	assign last = (cnt_q == CntW'(Digits - 1));
	always_comb begin
		if (last)
			dig = signed'({a_q[3], a_q[3:0]});
		else
			dig = signed'({1'b0, a_q[3:0]});
		part = dig * b_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= !ctl.start && run_q && last;
			if (ctl.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last)
					run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			a_q   <= PadW'(signed'(a));
			b_q   <= b;
			acc_q <= '0;
		end else if (run_q) begin
			a_q   <= a_q >> 4;
			acc_q <= acc_q + ((AW+BW)'(part) <<< (4 * cnt_q));
		end
	end

	assign p = acc_q;
endmodule

// ===== rtl/encoder_angle_iir_lowpass.sv =====
// Per-joint encoder angle filter.
// Input channel (in): one beat per sample or preset load, selected by mode.
// Output channel (out): joint_out, position, velocity for each mode-0 sample.
// Load beats and out-of-range joints give no output beat.
// Configuration: write enable cfg_we, index cfg_idx, data cfg_data;
// write only while idle.
// Each sample takes 9 digit-serial products on a single shared
// 4-bit-by-34-bit multiplier, each product running over 17 digits of
// the multiplicand; a new input beat is taken only when the block is
// back in its idle state.
// A load beat or an out-of-range joint passes through ST_ANGLE and back to idle.
// The history is held in a per-joint memory of six 48-bit words.
// Reset clears the primed flags and control state and loads the
// configuration registers with their defaults; history contents are undefined until written.
// A stalled receiver holds the result in the output register; the next
// input beat is taken and processed, and its result waits in the last
// step until the register drains, with the input blocked meanwhile.
module encoder_angle_iir_lowpass #(
	parameter int JOINT_COUNT = 16,
	parameter int ANGLE_WIDTH = 48
) (
	input  logic                               clk,
	input  logic                               arst_n,
	eaiir_if.sink                              in,
	eaiir_if.source                            out,
	input  logic                               cfg_we,
	input  logic [eaiir_pkg::CfgIdxW-1:0]      cfg_idx,
	input  logic [eaiir_pkg::CfgWidth-1:0]     cfg_data
);
	import eaiir_pkg::*;

	localparam int AW = 66;
	localparam int BW = 34;
	localparam int PW = AW + BW;
	localparam int JW = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
	localparam logic signed [PW-1:0] SatMax = PW'((66'sd1 <<< (ANGLE_WIDTH-1)) - 1);
	localparam logic signed [PW-1:0] SatMin = -(PW'(66'sd1) <<< (ANGLE_WIDTH-1));

	function automatic logic signed [AW-1:0] sat(input logic signed [PW-1:0] v);
		if (v > SatMax)
			sat = AW'(SatMax);
		else if (v < SatMin)
			sat = AW'(SatMin);
		else
			sat = AW'(v);
	endfunction

	logic [15:0]            inv_q;
	logic [31:0]            scale_q;
	logic signed [23:0]     bo_q, bi_q, a1_q, a2_q, a3_q;
	logic [15:0]            rate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q   <= '0;
			scale_q <= 32'd1727108828;
			bo_q    <= 24'sd30031;
			bi_q    <= 24'sd90083;
			a1_q    <= 24'sd1592675;
			a2_q    <= -24'sd1006633;
			a3_q    <= 24'sd222298;
			rate_q  <= 16'd1000;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_INVERT_MASK: inv_q   <= cfg_data[15:0];
				REG_ANGLE_SCALE: scale_q <= cfg_data;
				REG_B_OUTER:     bo_q    <= cfg_data[23:0];
				REG_B_INNER:     bi_q    <= cfg_data[23:0];
				REG_A_FIRST:     a1_q    <= cfg_data[23:0];
				REG_A_SECOND:    a2_q    <= cfg_data[23:0];
				REG_A_THIRD:     a3_q    <= cfg_data[23:0];
				REG_STEP_RATE:   rate_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// history memory: one row of six words per joint
	logic [6*ANGLE_WIDTH-1:0] hist_mem [JOINT_COUNT];
	logic [6*ANGLE_WIDTH-1:0] hist_rd_s1;
	logic [6*ANGLE_WIDTH-1:0] hist_wd;
	logic                     hist_we;
	logic [JW-1:0]            jt_q;
	logic [JOINT_COUNT-1:0]   primed_q;

	always_ff @(posedge clk) begin
		if (hist_we)
			hist_mem[jt_q] <= hist_wd;
		hist_rd_s1 <= hist_mem[jt_q];
	end

	state_t state_q, state_d;
	logic [3:0]            term_q;
	logic                  mode_q;
	logic [3:0]            jraw_q;
	logic signed [33:0]    diff_q;
	logic signed [AW-1:0]  xin_q;
	logic signed [AW-1:0]  angle_q, pos_q, vel_q;
	logic signed [AW-1:0]  h [6];
	logic signed [PW-1:0]  acc_q;
	logic                  pend_q;
	out_beat_t             res_q;

	mul_ctl_t              mctl;
	logic                  mdone;
	logic signed [PW-1:0]  mp;
	logic signed [AW-1:0]  ma;
	logic signed [BW-1:0]  mb;

	eaiir_sermul #(.AW(AW), .BW(BW)) u_mul (
		.clk(clk), .arst_n(arst_n), .ctl(mctl), .a(ma), .b(mb), .done(mdone), .p(mp)
	);

	always_comb begin
		for (int k = 0; k < 6; k++)
			h[k] = AW'(signed'(hist_rd_s1[k*ANGLE_WIDTH +: ANGLE_WIDTH]));
	end

	logic in_ok;
	logic out_go;
	assign in_ok = (jraw_q < JOINT_COUNT);
	assign in.ready = (state_q == ST_IDLE);
	assign out_go = (state_q == ST_OUT) && (!pend_q || out.ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in.valid && in.ready) state_d = ST_ANGLE;
			ST_ANGLE: begin
				if (!in_ok || mode_q) state_d = ST_IDLE;
				else if (mdone) state_d = ST_READ;
			end
			ST_READ:  state_d = ST_MAC;
			ST_MAC:   if (mdone && term_q == 4'd6) state_d = ST_VEL;
			ST_VEL:   if (mdone) state_d = ST_OUT;
			ST_OUT:   if (!pend_q || out.ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// operand select
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (state_q)
			ST_ANGLE: begin
				ma = AW'(diff_q);
				mb = BW'({1'b0, scale_q});
			end
			ST_VEL: begin
				ma = pos_q - (primed_q[jt_q] ? h[3] : angle_q);
				mb = BW'({1'b0, rate_q});
			end
			default: begin
				case (term_q)
					4'd0: begin ma = angle_q; mb = BW'(bo_q); end
					4'd1: begin ma = xin_q; mb = BW'(bi_q); end
					4'd2: begin ma = xin_q; mb = BW'(bi_q); end
					4'd3: begin ma = xin_q; mb = BW'(bo_q); end
					4'd4: begin ma = xin_q; mb = BW'(a1_q); end
					4'd5: begin ma = xin_q; mb = BW'(a2_q); end
					default: begin ma = xin_q; mb = BW'(a3_q); end
				endcase
			end
		endcase
	end

	logic signed [AW-1:0] load_ang;
	assign load_ang = sat(PW'(xin_q));

	logic [6*ANGLE_WIDTH-1:0] fill_row;
	always_comb begin
		for (int k = 0; k < 6; k++)
			fill_row[k*ANGLE_WIDTH +: ANGLE_WIDTH] = load_ang[ANGLE_WIDTH-1:0];
	end

	logic signed [AW-1:0] hsel [7];
	always_comb begin
		hsel[0] = angle_q;
		for (int k = 1; k < 7; k++)
			hsel[k] = primed_q[jt_q] ? h[k-1] : angle_q;
	end

	logic [2:0] hidx;
	assign hidx = (state_q == ST_READ || term_q == 4'd6) ? 3'd1 : 3'(term_q + 4'd1);

	// row words 0..5: x0 x1 x2 y0 y1 y2
	always_comb begin
		hist_we = 1'b0;
		hist_wd = fill_row;
		if (state_q == ST_ANGLE && in_ok && mode_q)
			hist_we = 1'b1;
		if (out_go) begin
			hist_we = 1'b1;
			hist_wd = {hsel[5][ANGLE_WIDTH-1:0], hsel[4][ANGLE_WIDTH-1:0],
				pos_q[ANGLE_WIDTH-1:0], hsel[2][ANGLE_WIDTH-1:0],
				hsel[1][ANGLE_WIDTH-1:0], angle_q[ANGLE_WIDTH-1:0]};
		end
	end

	logic mstart_q;
	assign mctl.start = mstart_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			primed_q <= '0;
			pend_q   <= 1'b0;
			term_q   <= '0;
			mstart_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && in.valid && in.ready)
				mstart_q <= (in.data.mode == 1'b0) && (in.data.joint_index < JOINT_COUNT);
			else
				mstart_q <= (state_q == ST_READ) || (state_q == ST_MAC && mdone);
			if (state_q == ST_READ)
				term_q <= '0;
			else if (state_q == ST_MAC && mdone)
				term_q <= term_q + 1'b1;
			if (out_go) begin
				primed_q[jt_q] <= 1'b1;
				pend_q         <= 1'b1;
			end else if (out.valid && out.ready) begin
				pend_q <= 1'b0;
			end
		end
	end

	logic signed [PW-1:0] rnd;
	always_comb rnd = (acc_q + mp + (PW'(1) <<< 19)) >>> 20;

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in.valid && in.ready) begin
			mode_q <= in.data.mode;
			jraw_q <= in.data.joint_index;
			jt_q   <= JW'(in.data.joint_index);
			xin_q  <= AW'(in.data.preset_angle);
			diff_q <= (inv_q[in.data.joint_index] ? -34'(signed'(in.data.enc_count))
				: 34'(signed'(in.data.enc_count))) - 34'(signed'(in.data.zero_count));
		end
		if (state_q == ST_ANGLE && !mode_q && mdone)
			angle_q <= sat((mp + (PW'(1) <<< 7)) >>> 8);
		if (state_q == ST_READ || (state_q == ST_MAC && mdone)) begin
			if (state_q == ST_READ)
				acc_q <= '0;
			else
				acc_q <= acc_q + mp;
			xin_q <= hsel[hidx];
		end
		if (state_q == ST_MAC && mdone && term_q == 4'd6)
			pos_q <= sat(rnd);
		if (state_q == ST_VEL && mdone)
			vel_q <= sat(mp);
		if (out_go) begin
			res_q.joint_out <= jraw_q;
			res_q.position  <= pos_q[FieldWidth-1:0];
			res_q.velocity  <= vel_q[FieldWidth-1:0];
		end
	end

	assign out.valid = pend_q;
	assign out.data  = res_q;
endmodule

// ===== rtl/eaiir_checker.sv =====
module eaiir_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input eaiir_pkg::out_beat_t out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("out dropped");
	a_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("in not blocked");
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data)) else $error("out data changed");
endmodule

bind encoder_angle_iir_lowpass eaiir_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in.valid), .in_ready(in.ready),
	.out_valid(out.valid), .out_ready(out.ready), .out_data(out.data)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import eaiir_pkg::*;

	localparam logic MODE_SAMPLE = 1'b0;
	localparam logic MODE_LOAD   = 1'b1;
	localparam int   JOINTS      = 16;
	localparam int   STALL_LIMIT = 5000;
	localparam int   DRAIN_WAIT  = 250;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_idx = '0;
	logic [CfgWidth-1:0] cfg_data = '0;

	eaiir_if #(.T(in_beat_t)) in_ch();
	eaiir_if #(.T(out_beat_t)) out_ch();

	encoder_angle_iir_lowpass dut (
		.clk(clk),
		.arst_n(arst_n),
		.in(in_ch),
		.out(out_ch),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// filter state and register copies
	logic [15:0]        m_invert;
	logic [31:0]        m_scale;
	logic signed [23:0] m_b_outer, m_b_inner, m_a_first, m_a_second, m_a_third;
	logic [15:0]        m_rate;
	logic signed [47:0] x_hist [JOINTS][3];
	logic signed [47:0] y_hist [JOINTS][3];
	bit                 primed [JOINTS];
	logic signed [31:0] last_count [JOINTS];

	out_beat_t pending_results[$];

	int errors = 0;
	int beats_in = 0;
	int loads_in = 0;
	int results_seen = 0;
	int settings_used = 0;
	int send_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_cycles = 0;
	int quiet_cycles = 0;

	initial in_ch.valid = 1'b0;
	initial in_ch.data = '0;

	function automatic logic signed [47:0] sat48(logic signed [127:0] v);
		logic signed [127:0] hi, lo;
		hi = (128'sd1 <<< 47) - 128'sd1;
		lo = -(128'sd1 <<< 47);
		if (v > hi)
			return hi[47:0];
		if (v < lo)
			return lo[47:0];
		return v[47:0];
	endfunction

	task automatic fill_joint(int j, logic signed [47:0] v);
		for (int k = 0; k < 3; k++) begin
			x_hist[j][k] = v;
			y_hist[j][k] = v;
		end
	endtask

	task automatic filter_update(in_beat_t b);
		logic signed [127:0] c, scale, acc, d, rate;
		logic signed [47:0]  ang, pos, vel;
		out_beat_t r;
		int j;
		j = b.joint_index;
		if (b.mode == MODE_LOAD) begin
			fill_joint(j, b.preset_angle);
			return;
		end
		c = b.enc_count;
		if (m_invert[j])
			c = -c;
		c = c - b.zero_count;
		scale = {96'd0, m_scale};
		ang = sat48((c * scale + 128'sd128) >>> 8);
		if (!primed[j]) begin
			fill_joint(j, ang);
			primed[j] = 1'b1;
		end
		acc = ang * m_b_outer;
		acc = acc + x_hist[j][0] * m_b_inner + x_hist[j][1] * m_b_inner;
		acc = acc + x_hist[j][2] * m_b_outer;
		acc = acc + y_hist[j][0] * m_a_first + y_hist[j][1] * m_a_second;
		acc = acc + y_hist[j][2] * m_a_third;
		pos = sat48((acc + (128'sd1 <<< 19)) >>> 20);
		rate = {112'd0, m_rate};
		d = pos;
		d = d - y_hist[j][0];
		vel = sat48(d * rate);
		x_hist[j][2] = x_hist[j][1];
		x_hist[j][1] = x_hist[j][0];
		x_hist[j][0] = ang;
		y_hist[j][2] = y_hist[j][1];
		y_hist[j][1] = y_hist[j][0];
		y_hist[j][0] = pos;
		r.joint_out = b.joint_index;
		r.position = pos;
		r.velocity = vel;
		pending_results.push_back(r);
	endtask

	task automatic send_beat(in_beat_t b);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= b;
		do @(posedge clk); while (!in_ch.ready);
		beats_in++;
		if (b.mode == MODE_LOAD)
			loads_in++;
		filter_update(b);
	endtask

	task automatic stop_sending();
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	function automatic in_beat_t make_beat(int joint, logic mode, logic signed [31:0] cnt,
		logic signed [31:0] off, logic signed [47:0] preset);
		in_beat_t b;
		b.mode = mode;
		b.joint_index = joint[3:0];
		b.enc_count = cnt;
		b.zero_count = off;
		b.preset_angle = preset;
		return b;
	endfunction

	function automatic in_beat_t random_beat();
		in_beat_t b;
		int j;
		j = $urandom_range(JOINTS - 1);
		b.mode = ($urandom_range(99) < 10) ? MODE_LOAD : MODE_SAMPLE;
		b.joint_index = j[3:0];
		b.zero_count = $signed($urandom_range(0, 4000)) - 2000;
		case ($urandom_range(9))
			0: begin
				b.enc_count = $urandom;
				b.zero_count = $urandom;
			end
			1: b.enc_count = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
			default: b.enc_count = last_count[j] + $signed($urandom_range(0, 400)) - 200;
		endcase
		last_count[j] = b.enc_count;
		if ($urandom_range(1))
			b.preset_angle = 48'({$urandom, $urandom});
		else
			b.preset_angle = 48'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
		return b;
	endfunction

	task automatic write_all_regs(logic [15:0] inv, logic [31:0] scale, logic [23:0] bo,
		logic [23:0] bi, logic [23:0] a1, logic [23:0] a2, logic [23:0] a3, logic [15:0] rate);
		logic [31:0] vals [8];
		cfg_reg_t idx [8];
		vals = '{{16'd0, inv}, scale, {8'd0, bo}, {8'd0, bi}, {8'd0, a1}, {8'd0, a2},
			{8'd0, a3}, {16'd0, rate}};
		idx = '{REG_INVERT_MASK, REG_ANGLE_SCALE, REG_B_OUTER, REG_B_INNER, REG_A_FIRST,
			REG_A_SECOND, REG_A_THIRD, REG_STEP_RATE};
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_idx <= idx[i];
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		m_invert = inv;
		m_scale = scale;
		m_b_outer = bo;
		m_b_inner = bi;
		m_a_first = a1;
		m_a_second = a2;
		m_a_third = a3;
		m_rate = rate;
		settings_used++;
	endtask

	task automatic run_random(int n, int idle_pct, int stall_pct);
		send_idle_pct = idle_pct;
		rx_stall_pct = stall_pct;
		for (int i = 0; i < n; i++)
			send_beat(random_beat());
		stop_sending();
	endtask

	task automatic test_directed();
		send_beat(make_beat(0, MODE_SAMPLE, 0, 0, 0));
		send_beat(make_beat(0, MODE_SAMPLE, 1000, 0, 0));
		send_beat(make_beat(0, MODE_SAMPLE, 1000, 0, 0));
		send_beat(make_beat(1, MODE_SAMPLE, 32'sh7fffffff, 32'sh80000000, 0));
		send_beat(make_beat(1, MODE_SAMPLE, 32'sh80000000, 32'sh7fffffff, 0));
		send_beat(make_beat(2, MODE_SAMPLE, 32'sh80000000, 0, 0));
		send_beat(make_beat(0, MODE_LOAD, 0, 0, 48'sh7fffffffffff));
		send_beat(make_beat(0, MODE_SAMPLE, 5, 5, 48'sh7fffffffffff));
		send_beat(make_beat(3, MODE_LOAD, 7, 7, 48'sh800000000000));
		send_beat(make_beat(3, MODE_SAMPLE, 100, -100, 0));
		send_beat(make_beat(3, MODE_SAMPLE, 100, -100, 0));
		send_beat(make_beat(15, MODE_LOAD, -1, -1, -48'sd1));
		send_beat(make_beat(15, MODE_SAMPLE, -1, -1, -48'sd1));
		send_beat(make_beat(15, MODE_SAMPLE, 32'sh7fffffff, 32'sh7fffffff, 0));
		stop_sending();
		// saturating coefficients, invert on every joint, zero step rate
		write_all_regs(16'hffff, 32'hffffffff, 24'h7fffff, 24'h7fffff, 24'h800000,
			24'h7fffff, 24'h800000, 16'd0);
		send_beat(make_beat(4, MODE_SAMPLE, 32'sh80000000, 32'sh7fffffff, 0));
		send_beat(make_beat(4, MODE_SAMPLE, 32'sh7fffffff, 32'sh80000000, 0));
		send_beat(make_beat(5, MODE_SAMPLE, 1, 0, 0));
		send_beat(make_beat(5, MODE_SAMPLE, -1, 0, 0));
		stop_sending();
	endtask

	task automatic test_settings_sweep();
		write_all_regs(16'h0000, 32'd1727108828, 24'd30031, 24'd90083, 24'd1592675,
			-24'sd1006633, 24'd222298, 16'd1000);
		run_random(70, 0, 0);
		run_random(65, 72, 0);
		write_all_regs(16'ha5a5, 32'hffffffff, 24'h7fffff, 24'h7fffff, 24'h7fffff,
			24'h7fffff, 24'h7fffff, 16'hffff);
		run_random(65, 0, 72);
		write_all_regs(16'h5a5a, 32'h00000000, 24'h800000, 24'h800000, 24'h800000,
			24'h800000, 24'h800000, 16'd1);
		run_random(60, 35, 35);
		write_all_regs(16'($urandom), $urandom, 24'($urandom), 24'($urandom),
			24'($urandom), 24'($urandom), 24'($urandom), 16'($urandom_range(1, 65535)));
		run_random(65, 35, 35);
		write_all_regs(16'h00ff, 32'd1727108828, 24'd30031, 24'd90083, 24'd1592675,
			-24'sd1006633, 24'd222298, 16'd0);
		run_random(60, 72, 0);
		write_all_regs(16'hff00, 32'd1727108828, 24'd30031, 24'd90083, 24'd1592675,
			-24'sd1006633, 24'd222298, 16'd1000);
		run_random(65, 0, 72);
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		rx_stall_pct = 0;
		hold_cycles = 900;
		for (int i = 0; i < 80; i++)
			send_beat(random_beat());
		stop_sending();
	endtask

	task automatic check_result(out_beat_t got);
		out_beat_t want;
		results_seen++;
		if (pending_results.size() == 0) begin
			$error("unexpected result beat: joint %0d", got.joint_out);
			errors++;
			return;
		end
		want = pending_results.pop_front();
		if (got.joint_out !== want.joint_out) begin
			$error("joint_out: expected %0d, got %0d", want.joint_out, got.joint_out);
			errors++;
		end
		if (got.position !== want.position) begin
			$error("position: expected %0d, got %0d", want.position, got.position);
			errors++;
		end
		if (got.velocity !== want.velocity) begin
			$error("velocity: expected %0d, got %0d", want.velocity, got.velocity);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready)
				check_result(out_ch.data);
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		m_invert = 16'h0000;
		m_scale = 32'd1727108828;
		m_b_outer = 24'sd30031;
		m_b_inner = 24'sd90083;
		m_a_first = 24'sd1592675;
		m_a_second = -24'sd1006633;
		m_a_third = 24'sd222298;
		m_rate = 16'd1000;
		for (int j = 0; j < JOINTS; j++) begin
			primed[j] = 1'b0;
			last_count[j] = 0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_settings_sweep();
		test_backpressure();
		$display("Sent %0d input beats (%0d preset loads), checked %0d results",
			beats_in, loads_in, results_seen);
		$display("across %0d register settings with idle, stall and hold-off phases",
			settings_used);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

// ===== encoder_angle_iir_lowpass.f =====
rtl/eaiir_pkg.sv
rtl/eaiir_if.sv
rtl/eaiir_sermul.sv
rtl/encoder_angle_iir_lowpass.sv
rtl/eaiir_checker.sv
verif/testbench.sv
